// File: hdl/mfde_pkg.sv
// Shared types and constants for the monochrome frame store draw engine.
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAGE_ROWS = 8;

    typedef enum logic [1:0] {
        FUNC_POINT  = 2'd0,
        FUNC_FILL   = 2'd1,
        FUNC_COLUMN = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

endpackage

`default_nettype wire

// File: hdl/mono_framebuffer_draw_engine_unit.sv
// Monochrome page-organized frame store with point, fill, column-write and read operations.
`timescale 1ns / 1ps
`default_nettype none

// The frame store is one single-port synchronous memory of PAGES x COLUMNS bytes that is
// updated by read-modify-write, through a read state and then a modify state per byte.
// After reset a clearing pass writes zero to every byte, during which no item is accepted.
// One item is processed at a time and holds the block until its result is loaded into the
// output register. It touches one byte for a point or a read, one or two for a column write,
// columns times pages for a fill rectangle, none for an empty or off-panel operation. The
// result beat is registered from the completion state; while an earlier result waits
// to be taken the finished item holds in its last state and no new item is accepted.
// Each item gives one result beat; read_data is zero for all but reads.
module mono_framebuffer_draw_engine_unit
    import mfde_pkg::*;
#(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_func,
    input  wire  [7:0]  i_x_start,
    input  wire  [7:0]  i_y_start,
    input  wire  [7:0]  i_x_end,
    input  wire  [7:0]  i_y_end,
    input  wire         i_pixel_on,
    input  wire  [7:0]  i_pattern,
    input  wire  [2:0]  i_page,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_read_data
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(COLUMNS);
    localparam int GW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROWS  = PAGES * PAGE_ROWS;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_MOD   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr;
    logic               r_is_rd;
    logic               r_on;
    logic [7:0]         r_pat;
    logic [XW-1:0]      r_x, r_xlo, r_xhi;
    logic [GW-1:0]      r_g, r_ghi;
    logic [7:0]         r_ylo, r_yhi;
    logic [7:0]         r_data;
    logic               r_ov;
    logic [7:0]         r_od;

    logic [7:0]         r_mem [DEPTH];
    logic [7:0]         r_rdata;

    logic               in_acc;
    logic               out_load;
    logic               we;
    logic [AW-1:0]      addr;
    logic [AW-1:0]      draw_addr;
    logic [GW-1:0]      pg_idx;
    logic [7:0]         wdata;
    logic [7:0]         mask, val;
    logic [7:0]         row_base, row, rel;

    logic [7:0]         xe_eff, xhi8;
    logic [8:0]         yhi9;
    logic [7:0]         yhi8;
    logic               empty;
    logic               rd_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_read_data = r_od;

    // Accept-time range setup
    always_comb begin
        xe_eff = (t_func'(i_func) == FUNC_FILL) ? i_x_end : i_x_start;
        xhi8   = (xe_eff > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : xe_eff;
        case (t_func'(i_func))
            FUNC_FILL:   yhi9 = {1'b0, i_y_end};
            FUNC_COLUMN: yhi9 = {1'b0, i_y_start} + 9'd7;
            default:     yhi9 = {1'b0, i_y_start};
        endcase
        if (yhi9 > 9'(ROWS - 1)) begin
            yhi9 = 9'(ROWS - 1);
        end
        yhi8  = yhi9[7:0];
        empty = (i_x_start > xhi8) || ({1'b0, i_y_start} > yhi9);
        rd_ok = ({2'b0, i_page} < 5'(PAGES)) && (i_x_start <= 8'(COLUMNS - 1));
    end

    // Byte mask and data for the current page/column
    always_comb begin
        row_base = 8'(r_g) << 3;
        mask     = '0;
        val      = '0;
        row      = '0;
        rel      = '0;
        for (int k = 0; k < PAGE_ROWS; k++) begin
            row         = row_base | 8'(k);
            rel         = row - r_ylo;
            mask[7 - k] = (row >= r_ylo) && (row <= r_yhi);
            val[7 - k]  = ~(r_pat[rel[2:0]] ^ r_on);
        end
    end

    assign pg_idx    = GW'(PAGES - 1) - r_g;
    assign draw_addr = AW'(pg_idx) * AW'(COLUMNS) + AW'(r_x);
    assign we        = (r_state == S_CLEAR) || ((r_state == S_MOD) && !r_is_rd);
    assign addr      = (r_state == S_CLEAR) ? r_clr : draw_addr;
    assign wdata     = (r_state == S_CLEAR) ? 8'd0 : ((r_rdata & ~mask) | (val & mask));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= wdata;
        end
        r_rdata <= r_mem[addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (t_func'(i_func) == FUNC_READ) begin
                        n_state = rd_ok ? S_RD : S_DONE;
                    end else begin
                        n_state = empty ? S_DONE : S_RD;
                    end
                end
            end
            S_RD: n_state = S_MOD;
            S_MOD: begin
                if (r_is_rd || ((r_x == r_xhi) && (r_g == r_ghi))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_od <= r_data;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_is_rd <= (t_func'(i_func) == FUNC_READ);
                    r_on    <= i_pixel_on;
                    r_pat   <= (t_func'(i_func) == FUNC_COLUMN) ? i_pattern : 8'hFF;
                    r_x     <= XW'(i_x_start);
                    r_xlo   <= XW'(i_x_start);
                    r_xhi   <= XW'(xhi8);
                    r_ylo   <= i_y_start;
                    r_yhi   <= yhi8;
                    r_ghi   <= GW'(yhi8 >> 3);
                    r_data  <= 8'd0;
                    if (t_func'(i_func) == FUNC_READ) begin
                        r_g <= GW'(5'(PAGES - 1) - {2'b0, i_page});
                    end else begin
                        r_g <= GW'(i_y_start >> 3);
                    end
                end
            end
            S_MOD: begin
                if (r_is_rd) begin
                    r_data <= r_rdata;
                end else if (r_x == r_xhi) begin
                    r_x <= r_xlo;
                    r_g <= r_g + GW'(1);
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE || r_state == S_RD) |-> !we)
        else $error("frame store written outside clear or modify");

    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && !r_is_rd) |-> (r_x >= r_xlo && r_x <= r_xhi))
        else $error("column walk left its range");

    a_g_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && !r_is_rd) |-> (r_g <= r_ghi))
        else $error("page walk passed its last page");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");
`endif

endmodule

`default_nettype wire

// File: tb/tb_mono_framebuffer_draw_engine_unit.sv
// Testbench for the monochrome frame store draw engine, with a mirrored frame store.
`timescale 1ns / 1ps

module tb_mono_framebuffer_draw_engine_unit;
    import mfde_pkg::*;

    localparam int PAGES           = 8;
    localparam int COLUMNS         = 128;
    localparam int ROWS            = PAGES * PAGE_ROWS;
    localparam int RANDOM_BEATS    = 1600;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        t_func       func;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic        pixel_on;
        logic [7:0]  pattern;
        logic [2:0]  page;
    } t_draw_cmd;

    class frame_mirror;
        logic [7:0] pixel_bytes [PAGES*COLUMNS];
        logic [7:0] expected_bytes [$];
        int         mismatches;

        function new();
            foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
            mismatches = 0;
        endfunction

        function void set_pixel(int x, int y, logic lit);
            int         idx;
            logic [7:0] mask;
            if (x >= COLUMNS || y >= ROWS) return;
            idx  = (PAGES - 1 - y / PAGE_ROWS) * COLUMNS + x;
            mask = 8'h80 >> (y % PAGE_ROWS);
            if (lit) pixel_bytes[idx] = pixel_bytes[idx] | mask;
            else     pixel_bytes[idx] = pixel_bytes[idx] & ~mask;
        endfunction

        function void apply_item(t_draw_cmd c);
            logic [7:0] rd;
            int         xe, ye, x, y, t;
            rd = '0;
            case (c.func)
                FUNC_POINT: set_pixel(int'(c.x_start), int'(c.y_start), c.pixel_on);
                FUNC_FILL: begin
                    xe = (c.x_end > COLUMNS - 1) ? COLUMNS - 1 : int'(c.x_end);
                    ye = (c.y_end > ROWS - 1) ? ROWS - 1 : int'(c.y_end);
                    for (x = int'(c.x_start); x <= xe; x++)
                        for (y = int'(c.y_start); y <= ye; y++)
                            set_pixel(x, y, c.pixel_on);
                end
                FUNC_COLUMN: begin
                    for (t = 0; t < PAGE_ROWS; t++)
                        set_pixel(int'(c.x_start), int'(c.y_start) + t,
                                  c.pattern[t] ? c.pixel_on : !c.pixel_on);
                end
                FUNC_READ: begin
                    if (c.page < PAGES && c.x_start < COLUMNS)
                        rd = pixel_bytes[c.page * COLUMNS + c.x_start];
                end
                default: begin
                end
            endcase
            expected_bytes.push_back(rd);
        endfunction

        function void check_read_data(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat, read_data=%02h", got);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("read_data mismatch: expected %02h, got %02h", want, got);
                end
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_ready = 1'b0;
    t_draw_cmd  cmd_q     = '0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] read_data;

    frame_mirror sb;
    int          stall_cycles = 0;
    int          sent_beats   = 0;
    bit          send_calm    = 1'b0;

    mono_framebuffer_draw_engine_unit #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_func      (cmd_q.func),
        .i_x_start   (cmd_q.x_start),
        .i_y_start   (cmd_q.y_start),
        .i_x_end     (cmd_q.x_end),
        .i_y_end     (cmd_q.y_end),
        .i_pixel_on  (cmd_q.pixel_on),
        .i_pattern   (cmd_q.pattern),
        .i_page      (cmd_q.page),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_read_data (read_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.apply_item(cmd_q);
            if (out_valid && out_ready) sb.check_read_data(read_data);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_cmd(input t_draw_cmd c);
        int gap;
        if (sent_beats % 64 == 0) send_calm = ($urandom_range(0, 2) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_q    <= c;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_beats++;
    endtask

    task automatic issue(input t_func f, input logic [7:0] xs, input logic [7:0] ys,
                         input logic [7:0] xe, input logic [7:0] ye, input logic lit,
                         input logic [7:0] pat, input logic [2:0] pg);
        t_draw_cmd c;
        c.func     = f;
        c.x_start  = xs;
        c.y_start  = ys;
        c.x_end    = xe;
        c.y_end    = ye;
        c.pixel_on = lit;
        c.pattern  = pat;
        c.page     = pg;
        send_cmd(c);
    endtask

    function automatic logic [7:0] clip8(int v);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [7:0] pick_x();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, COLUMNS - 1))
                                            : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_y();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ROWS - 1))
                                            : 8'($urandom_range(0, 255));
    endfunction

    function automatic t_draw_cmd random_cmd();
        t_draw_cmd c;
        int        sel;
        c.x_start  = 8'($urandom_range(0, 255));
        c.y_start  = 8'($urandom_range(0, 255));
        c.x_end    = 8'($urandom_range(0, 255));
        c.y_end    = 8'($urandom_range(0, 255));
        c.pixel_on = 1'($urandom_range(0, 1));
        c.pattern  = 8'($urandom_range(0, 255));
        c.page     = 3'($urandom_range(0, 7));
        sel = $urandom_range(0, 99);
        if (sel < 30)      c.func = FUNC_POINT;
        else if (sel < 50) c.func = FUNC_FILL;
        else if (sel < 75) c.func = FUNC_COLUMN;
        else               c.func = FUNC_READ;
        case (c.func)
            FUNC_POINT, FUNC_COLUMN: begin
                c.x_start = pick_x();
                c.y_start = pick_y();
            end
            FUNC_FILL: begin
                c.x_start = pick_x();
                c.y_start = pick_y();
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    c.x_start = 8'($urandom_range(0, 15));
                    c.y_start = 8'($urandom_range(0, 15));
                    c.x_end   = 8'($urandom_range(100, 255));
                    c.y_end   = 8'($urandom_range(40, 255));
                end else if (sel < 10) begin
                    c.x_start = 8'($urandom_range(1, 255));
                    c.x_end   = 8'($urandom_range(0, c.x_start - 1));
                    c.y_end   = clip8(c.y_start + $urandom_range(0, 15));
                end else if (sel < 17) begin
                    c.y_start = 8'($urandom_range(1, 255));
                    c.y_end   = 8'($urandom_range(0, c.y_start - 1));
                    c.x_end   = clip8(c.x_start + $urandom_range(0, 7));
                end else begin
                    c.x_end = clip8(c.x_start + $urandom_range(0, 7));
                    if ($urandom_range(0, 99) < 15)
                        c.y_end = 8'($urandom_range(c.y_start, 255));
                    else
                        c.y_end = clip8(c.y_start + $urandom_range(0, 23));
                end
            end
            FUNC_READ: begin
                c.x_start = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, COLUMNS - 1))
                                                        : 8'($urandom_range(0, 255));
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    initial begin : drain
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 15);
            if (taken == 300 || taken == 1000) gap = HOLD_OFF_CYCLES;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : stimulus
        int n;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        issue(FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd0);
        issue(FUNC_POINT,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd7);
        issue(FUNC_POINT,  8'd127, 8'd63,  8'd0,   8'd0,   1'b1, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd127, 8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd0);
        // off-panel pixels are dropped
        issue(FUNC_POINT,  8'd128, 8'd0,   8'd0,   8'd0,   1'b1, 8'h00, 3'd0);
        issue(FUNC_POINT,  8'd0,   8'd64,  8'd0,   8'd0,   1'b1, 8'h00, 3'd0);
        issue(FUNC_POINT,  8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd7);
        // ends clamp to the panel
        issue(FUNC_FILL,   8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd64,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd4);
        // start after end draws nothing
        issue(FUNC_FILL,   8'd20,  8'd0,   8'd10,  8'd63,  1'b0, 8'h00, 3'd0);
        issue(FUNC_FILL,   8'd0,   8'd30,  8'd127, 8'd29,  1'b0, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd15,  8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd3);
        issue(FUNC_POINT,  8'd5,   8'd5,   8'd0,   8'd0,   1'b0, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd5,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd7);
        issue(FUNC_FILL,   8'd0,   8'd0,   8'd127, 8'd63,  1'b0, 8'h00, 3'd0);
        issue(FUNC_READ,   8'd127, 8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd7);
        // column runs off the bottom, then inverted polarity
        issue(FUNC_COLUMN, 8'd3,   8'd60,  8'd0,   8'd0,   1'b1, 8'hA5, 3'd0);
        issue(FUNC_READ,   8'd3,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd0);
        issue(FUNC_COLUMN, 8'd4,   8'd0,   8'd0,   8'd0,   1'b0, 8'h0F, 3'd0);
        issue(FUNC_READ,   8'd4,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 3'd7);
        issue(FUNC_COLUMN, 8'd200, 8'd10,  8'd0,   8'd0,   1'b1, 8'hFF, 3'd0);
        issue(FUNC_COLUMN, 8'd10,  8'd250, 8'd0,   8'd0,   1'b1, 8'hFF, 3'd0);

        for (n = 0; n < RANDOM_BEATS; n++) send_cmd(random_cmd());
        in_valid <= 1'b0;

        do @(posedge clk); while (sb.expected_bytes.size() != 0);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/mfde_pkg.sv
hdl/mono_framebuffer_draw_engine_unit.sv
tb/tb_mono_framebuffer_draw_engine_unit.sv
